@@ rtl/scale_note_to_frequency_assert.svh @@
// Assertion macros shared by the scale note to frequency modules.
`ifndef SCALE_NOTE_TO_FREQUENCY_ASSERT_SVH
`define SCALE_NOTE_TO_FREQUENCY_ASSERT_SVH
`ifndef SYNTH
`define SNF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("snf assertion failed");
`define SNF_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("snf forbidden condition");
`else
`define SNF_ASSERT(label, clk, rst, prop)
`define SNF_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/snf_pkg.sv @@
// Types, constants and tables for the scale note to frequency block.
package snf_pkg;

  localparam int DEFAULT_MAX_DEGREES = 128;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  localparam logic [31:0] Q28_ONE  = 32'd268435456;
  localparam logic [31:0] Q28_TWO  = 32'd536870912;
  localparam logic [63:0] Q28_HALF = 64'd134217728;
  localparam logic [31:0] FREQ_MAX = 32'hFFFF_FFFF;

  localparam logic [7:0] ET_DEGREES = 8'd12;
  localparam int         ET_SLOTS   = 11;

  localparam logic [7:0]  RST_SCALE_SIZE     = 8'd12;
  localparam logic [31:0] RST_PERIOD_RATIO   = 32'd536870912;
  localparam logic [6:0]  RST_REFERENCE_NOTE = 7'd60;
  localparam logic [31:0] RST_REFERENCE_FREQ = 32'd17145893;

  localparam int SDIV_STEPS = 7;
  localparam int LDIV_STEPS = 32;

  typedef enum logic [1:0] {
    REG_SCALE_SIZE     = 2'd0,
    REG_PERIOD_RATIO   = 2'd1,
    REG_REFERENCE_NOTE = 2'd2,
    REG_REFERENCE_FREQ = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FIX,
    ST_ROUTE,
    ST_PMUL,
    ST_PDIV_INIT,
    ST_PDIV_STEP,
    ST_SELECT,
    ST_RMUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        op;
    logic [6:0]  note;
    logic [31:0] root_freq;
    logic [6:0]  root_note;
    logic [6:0]  entry_index;
    logic [31:0] entry_ratio;
  } in_word_t;

  typedef struct packed {
    logic [31:0] frequency;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fix;
    logic pmul;
    logic pdiv_init;
    logic pdiv_step;
    logic select;
    logic rmul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic ldiv_last;
    logic q_zero;
    logic q_one;
    logic q_neg;
    logic sat;
  } stat_t;

  function automatic logic [31:0] et_ratio(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'd268435456;
      4'd1:    v = 32'd284397459;
      4'd2:    v = 32'd301308612;
      4'd3:    v = 32'd319225354;
      4'd4:    v = 32'd338207482;
      4'd5:    v = 32'd358318345;
      4'd6:    v = 32'd379625062;
      4'd7:    v = 32'd402198743;
      4'd8:    v = 32'd426114725;
      4'd9:    v = 32'd451452825;
      4'd10:   v = 32'd478297607;
      4'd11:   v = 32'd506738663;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Slots reachable by a 7-bit write index.
  function automatic int tbl_depth(input int max_deg);
    return (max_deg - 1 < 128) ? max_deg - 1 : 128;
  endfunction

  function automatic int tbl_addr_w(input int max_deg);
    return (tbl_depth(max_deg) > 1) ? $clog2(tbl_depth(max_deg)) : 1;
  endfunction

endpackage

@@ rtl/snf_table.sv @@
// Ratio table memory with per-entry valid bits and equal temperament reset values.
module snf_table #(
  parameter int MAX_DEGREES = snf_pkg::DEFAULT_MAX_DEGREES
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    wr_en,
  input  logic [snf_pkg::tbl_addr_w(MAX_DEGREES)-1:0] wr_addr,
  input  logic [31:0]                             wr_data,
  input  logic [snf_pkg::tbl_addr_w(MAX_DEGREES)-1:0] rd_addr,
  output logic [31:0]                             rd_data
);
  import snf_pkg::*;

  localparam int AW    = tbl_addr_w(MAX_DEGREES);
  localparam int WORDS = 1 << AW;

  logic [31:0]      mem [WORDS];
  logic [WORDS-1:0] valid;
  logic [31:0]      mem_q;
  logic             valid_q;
  logic [AW-1:0]    addr_q;
  logic [31:0]      reset_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  always_comb begin
    if (32'(addr_q) < 32'(ET_SLOTS)) begin
      reset_val = et_ratio(4'(addr_q) + 4'd1);
    end else begin
      reset_val = '0;
    end
    rd_data = valid_q ? mem_q : reset_val;
  end

endmodule

@@ rtl/snf_dp.sv @@
// Datapath: note divider, period power loop, long divider, ratio multiply and result register.
`include "scale_note_to_frequency_assert.svh"
module snf_dp #(
  parameter int MAX_DEGREES = snf_pkg::DEFAULT_MAX_DEGREES
) (
  input  logic               clk,
  input  logic               rst,
  input  snf_pkg::cmd_t      cmd,
  output snf_pkg::stat_t     stat,
  input  snf_pkg::in_word_t  in_word,
  input  logic [7:0]         scale_size,
  input  logic [31:0]        period_ratio,
  input  logic [6:0]         reference_note,
  input  logic [31:0]        reference_freq,
  output snf_pkg::out_word_t out_word
);
  import snf_pkg::*;

  localparam int TBL_DEPTH = tbl_depth(MAX_DEGREES);
  localparam int AW        = tbl_addr_w(MAX_DEGREES);

  logic        fb;
  logic [7:0]  divisor;
  logic [6:0]  dv_num;
  logic [7:0]  dv_rem;
  logic [6:0]  dv_quo;
  logic [2:0]  dv_cnt;
  logic        neg;
  logic [7:0]  q_mag;
  logic        q_neg;
  logic [7:0]  r;
  logic [31:0] acc;
  logic [31:0] p;
  logic        sat;
  logic [31:0] ratio;
  logic [31:0] ld_rem;
  logic [31:0] ld_quo;
  logic [4:0]  ld_cnt;

  logic [7:0]  n_eff;
  logic        fb_in;
  logic [7:0]  diff;
  logic [8:0]  dv_t;
  logic        dv_ge;
  logic [63:0] prod;
  logic [35:0] mul_next;
  logic        mul_ovf;
  logic [60:0] ld_num;
  logic        ldiv_ovf;
  logic [32:0] ld_t;
  logic        ld_ge;
  logic [31:0] ld_rem_next;
  logic [31:0] ld_quo_next;
  logic [7:0]  r_idx;
  logic        r_in_range;
  logic [31:0] tbl_rd;
  logic        tbl_wr_en;

  always_comb begin
    if (scale_size == 8'd0) begin
      n_eff = 8'd1;
    end else if (32'(scale_size) > 32'(MAX_DEGREES)) begin
      n_eff = 8'(MAX_DEGREES);
    end else begin
      n_eff = scale_size;
    end
    fb_in = (n_eff == 8'd1);
    if (fb_in) begin
      diff = {1'b0, in_word.note} - {1'b0, in_word.root_note};
    end else begin
      diff = {1'b0, in_word.note} - {1'b0, reference_note};
    end

    dv_t  = {dv_rem, dv_num[6]};
    dv_ge = (dv_t >= {1'b0, divisor});

    prod     = 64'(acc) * (cmd.rmul ? 64'(ratio) : 64'(p)) + Q28_HALF;
    mul_next = prod[63:28];
    mul_ovf  = |mul_next[35:32];

    ld_num   = {1'b0, acc, 28'd0} + {30'd0, p[31:1]};
    ldiv_ovf = ({3'd0, ld_num[60:32]} >= p);

    ld_t        = {ld_rem, ld_quo[31]};
    ld_ge       = (ld_t >= {1'b0, p});
    ld_rem_next = ld_ge ? 32'(ld_t - {1'b0, p}) : ld_t[31:0];
    ld_quo_next = {ld_quo[30:0], ld_ge};

    r_idx      = r - 8'd1;
    r_in_range = (r_idx < 8'(TBL_DEPTH));

    tbl_wr_en = cmd.load && (in_word.op == OP_WRITE)
                && ({1'b0, in_word.entry_index} < 8'(TBL_DEPTH));

    stat.div_last  = (dv_cnt == 3'(SDIV_STEPS - 1));
    stat.ldiv_last = (ld_cnt == 5'(LDIV_STEPS - 1));
    stat.q_zero    = (q_mag == 8'd0);
    stat.q_one     = (q_mag == 8'd1);
    stat.q_neg     = q_neg;
    stat.sat       = sat;
  end

  snf_table #(
    .MAX_DEGREES(MAX_DEGREES)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (tbl_wr_en),
    .wr_addr(in_word.entry_index[AW-1:0]),
    .wr_data(in_word.entry_ratio),
    .rd_addr(r_idx[AW-1:0]),
    .rd_data(tbl_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fb      <= fb_in;
      divisor <= fb_in ? ET_DEGREES : n_eff;
      neg     <= diff[7];
      dv_num  <= diff[7] ? 7'(8'd0 - diff) : diff[6:0];
      dv_rem  <= '0;
      dv_quo  <= '0;
      dv_cnt  <= '0;
      p       <= fb_in ? Q28_TWO : period_ratio;
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? 8'(dv_t - {1'b0, divisor}) : dv_t[7:0];
      dv_num <= {dv_num[5:0], 1'b0};
      dv_quo <= {dv_quo[5:0], dv_ge};
      dv_cnt <= dv_cnt + 3'd1;
    end

    if (cmd.fix) begin
      q_neg <= neg;
      if (!neg || dv_rem == 8'd0) begin
        q_mag <= {1'b0, dv_quo};
        r     <= dv_rem;
      end else begin
        q_mag <= {1'b0, dv_quo} + 8'd1;
        r     <= divisor - dv_rem;
      end
    end else if ((cmd.pmul && !sat) || (cmd.pdiv_step && stat.ldiv_last)) begin
      q_mag <= q_mag - 8'd1;
    end

    if (cmd.pdiv_init) begin
      ld_rem <= {3'd0, ld_num[60:32]};
      ld_quo <= ld_num[31:0];
      ld_cnt <= '0;
    end else if (cmd.pdiv_step) begin
      ld_rem <= ld_rem_next;
      ld_quo <= ld_quo_next;
      ld_cnt <= ld_cnt + 5'd1;
    end

    if (cmd.select) begin
      if (fb) begin
        ratio <= et_ratio(r[3:0]);
      end else if (r == 8'd0) begin
        ratio <= Q28_ONE;
      end else if (r_in_range) begin
        ratio <= tbl_rd;
      end else begin
        ratio <= '0;
      end
    end

    if (cmd.load) begin
      if (in_word.op == OP_WRITE) begin
        acc <= '0;
      end else begin
        acc <= fb_in ? in_word.root_freq : reference_freq;
      end
    end else if (!sat) begin
      if (cmd.pmul || cmd.rmul) begin
        acc <= mul_ovf ? FREQ_MAX : mul_next[31:0];
      end else if (cmd.pdiv_init && ldiv_ovf) begin
        acc <= FREQ_MAX;
      end else if (cmd.pdiv_step && stat.ldiv_last) begin
        acc <= ld_quo_next;
      end
    end

    if (cmd.emit) begin
      out_word.frequency <= acc;
      out_word.saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (cmd.load) begin
      sat <= 1'b0;
    end else if (!sat && (((cmd.pmul || cmd.rmul) && mul_ovf)
                          || (cmd.pdiv_init && ldiv_ovf))) begin
      sat <= 1'b1;
    end
  end

  `SNF_ASSERT(a_ldiv_rem_below_divisor, clk, rst, cmd.pdiv_step |-> ld_rem < p)
  `SNF_ASSERT(a_sat_holds_max, clk, rst, sat |-> acc == FREQ_MAX)
  `SNF_ASSERT_NEVER(a_no_period_step_after_sat, clk, rst, sat && (cmd.pmul || cmd.pdiv_step))

endmodule

@@ rtl/snf_ctrl.sv @@
// Controller: sequences one item through the datapath and drives both handshakes.
`include "scale_note_to_frequency_assert.svh"
module snf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  snf_pkg::stat_t stat,
  output snf_pkg::cmd_t  cmd
);
  import snf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = (state != ST_IDLE);
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_op == OP_WRITE) ? ST_DONE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_ROUTE;
      end
      ST_ROUTE: begin
        priority if (stat.q_zero) begin
          state_next = ST_SELECT;
        end else if (stat.q_neg) begin
          state_next = ST_PDIV_INIT;
        end else begin
          state_next = ST_PMUL;
        end
      end
      ST_PMUL: begin
        priority if (stat.sat) begin
          state_next = ST_SELECT;
        end else begin
          cmd.pmul = 1'b1;
          if (stat.q_one) begin
            state_next = ST_SELECT;
          end
        end
      end
      ST_PDIV_INIT: begin
        cmd.pdiv_init = 1'b1;
        state_next    = ST_PDIV_STEP;
      end
      ST_PDIV_STEP: begin
        priority if (stat.sat) begin
          state_next = ST_SELECT;
        end else begin
          cmd.pdiv_step = 1'b1;
          if (stat.ldiv_last) begin
            state_next = stat.q_one ? ST_SELECT : ST_PDIV_INIT;
          end
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_RMUL;
      end
      ST_RMUL: begin
        cmd.rmul   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SNF_ASSERT(a_emit_only_when_free, clk, rst, cmd.emit |-> (!out_valid || !out_stall))
  `SNF_ASSERT(a_emit_fills_output, clk, rst, cmd.emit |=> out_valid)
  `SNF_ASSERT(a_hold_done_while_full, clk, rst, (state == ST_DONE && out_valid && out_stall) |=> state == ST_DONE)

endmodule

@@ rtl/scale_note_to_frequency.sv @@
// Top level of the scale note to frequency converter: configuration registers, controller and datapath.
// Converts a MIDI note to a Q16.16 frequency through a table of Q4.28 degree ratios, or through
// twelve-tone equal temperament from the word's root note and root frequency when the scale size
// is one or zero. One word is in flight at a time; a finished result waits in the output register
// while the next word is taken. A conversion runs the note division, then a period loop of |q|
// steps, q being the floored period count: one 32x32 multiply per period when the note lies at or
// above the reference, or one bit-serial 32-step long division per period below it, then the ratio
// select and multiply; a saturating result leaves the period loop early. The ratio table holds
// MAX_DEGREES-1 entries, at most 128, with a valid bit each and needs no clearing pass after reset.
module scale_note_to_frequency #(
  parameter int MAX_DEGREES = snf_pkg::DEFAULT_MAX_DEGREES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  snf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output snf_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  snf_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]        cfg_data
);
  import snf_pkg::*;

  logic [7:0]  scale_size;
  logic [31:0] period_ratio;
  logic [6:0]  reference_note;
  logic [31:0] reference_freq;
  cmd_t        cmd;
  stat_t       stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_size     <= RST_SCALE_SIZE;
      period_ratio   <= RST_PERIOD_RATIO;
      reference_note <= RST_REFERENCE_NOTE;
      reference_freq <= RST_REFERENCE_FREQ;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE_SIZE:     scale_size     <= cfg_data[7:0];
        REG_PERIOD_RATIO:   period_ratio   <= cfg_data;
        REG_REFERENCE_NOTE: reference_note <= cfg_data[6:0];
        REG_REFERENCE_FREQ: reference_freq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  snf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  snf_dp #(
    .MAX_DEGREES(MAX_DEGREES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_word       (in_word),
    .scale_size    (scale_size),
    .period_ratio  (period_ratio),
    .reference_note(reference_note),
    .reference_freq(reference_freq),
    .out_word      (out_word)
  );

endmodule
